>>> design/w5fr_pkg.sv
// Shared widths, constants, types and helper functions for the WENO5 face reconstruction.
`default_nettype none

package w5fr_pkg;

  localparam int DATA_W = 32;  // Q12.20 cell values and results
  localparam int EPS_W  = 20;  // smoothness offset register
  localparam int MAG_W  = 35;  // magnitude of a stencil difference
  localparam int SQ_W   = 49;  // floor(x*x / 2^20)
  localparam int S_W    = 48;  // offset smoothness indicator
  localparam int DIV_W  = 46;  // divider operand width after normalising
  localparam int QUO_W  = 25;  // quotient bits, floor(n * 2^24 / d) for n <= d
  localparam int WBITS  = 24;  // weight fraction bits
  localparam int RBITS  = 16;  // ratio fraction bits
  localparam int T_W    = RBITS + 1;
  localparam int A_W    = 36;  // raw weights and their sum
  localparam int N_W    = 37;  // candidate numerators

  // floor(x/3) = H*(2^24-1)/3 + floor((H+L)/3) for x = H*2^24 + L
  localparam logic [22:0] DIV3_HI_MUL = 23'd5592405;
  localparam logic [31:0] DIV3_RECIP  = 32'hAAAAAAAB;

  typedef struct packed {
    logic                  zero;
    logic signed [N_W-1:0] n1;
    logic signed [N_W-1:0] n2;
    logic signed [N_W-1:0] n3;
  } side_t;

  // floor(x/3) for x < 2^25
  function automatic logic [23:0] div3_fold(input logic [24:0] x);
    logic [56:0] p;
    p = 57'(x) * 57'(DIV3_RECIP);
    return p[56:33];
  endfunction

endpackage

`default_nettype wire

>>> design/w5fr_if.sv
// Valid/ready channel interfaces for face items and reconstructed results.
`default_nettype none

interface w5fr_in_if import w5fr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] value_m2;
  logic signed [DATA_W-1:0] value_m1;
  logic signed [DATA_W-1:0] value_c0;
  logic signed [DATA_W-1:0] value_p1;
  logic signed [DATA_W-1:0] value_p2;
  logic signed [DATA_W-1:0] value_p3;

  modport source (output valid, velocity, value_m2, value_m1, value_c0, value_p1,
                  value_p2, value_p3, input ready);
  modport sink (input valid, velocity, value_m2, value_m1, value_c0, value_p1,
                value_p2, value_p3, output ready);
endinterface

interface w5fr_out_if import w5fr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] face_value;

  modport source (output valid, face_value, input ready);
  modport sink (input valid, face_value, output ready);
endinterface

`default_nettype wire

>>> design/w5fr_div.sv
// Pipelined restoring divider: floor(num * 2^24 / den) for num <= den, one bit per stage.
`default_nettype none

module w5fr_div import w5fr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0] rem_q [QUO_W];
  logic [DIV_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DIV_W:0]   rem_in;
    logic [DIV_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      // num <= den, so the top quotient bit is set only on equality
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = {rem_q[k-1], 1'b0};
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign diff = rem_in - {1'b0, den_in};
    assign ge   = rem_in >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DIV_W-1:0] : rem_in[DIV_W-1:0];
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

>>> design/weno5_face_reconstruction.sv
// Top level: fifth-order WENO face reconstruction pipeline.
//
// While the output is taken, one face item enters per clock; the full-rate pipe
// sustains one item per cycle. Two 25-stage restoring dividers in series
// dominate the depth: one triple forms the smoothness ratios t_k, the next pair
// forms the Q1.24 weights w1 and w3. The rest is short: stencil select and
// numerators, squaring in 20-bit partial products, the /12 of the indicator by
// a fold-and-reciprocal trick, min search, ratio squares, split 25x37 weighted
// products, and a final rounded divide by 6*2^24 with saturation. Every stage
// carries a valid bit; when the output item is not taken the whole pipe holds,
// so nothing is lost or repeated, and bubbles flow through as invalid stages.
// Zero velocity gives zero. smoothness_epsilon must be written through
// cfg_we_i/cfg_wdata_i only while the pipe is empty; the block does not enforce
// it. A value of zero acts as one.
`default_nettype none

module weno5_face_reconstruction import w5fr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_wdata_i,
  w5fr_in_if.sink          face_in_i,
  w5fr_out_if.source       face_out_o
);

  // stage numbers: register k is the k-th register an item passes after acceptance
  localparam int ST_DIV_IN = 7;
  localparam int ST_T      = ST_DIV_IN + QUO_W;
  localparam int ST_TSQ    = ST_T + 1;
  localparam int ST_A      = ST_TSQ + 1;
  localparam int ST_W      = ST_A + QUO_W;
  localparam int ST_WREG   = ST_W + 1;
  localparam int ST_PP     = ST_WREG + 1;
  localparam int ST_P      = ST_PP + 1;
  localparam int ST_ACC    = ST_P + 1;
  localparam int ST_DIV3   = ST_ACC + 1;
  localparam int NST       = ST_DIV3 + 1;

  localparam logic [T_W-1:0]       T_ONE     = T_W'(1) << RBITS;
  localparam logic [QUO_W-1:0]     W_ONE     = QUO_W'(1) << WBITS;
  localparam logic signed [63:0]   ACC_ROUND = 64'sd3 <<< WBITS;
  localparam logic [38:0]          U_OFFSET  = 39'd3 << 35;
  localparam logic signed [39:0]   F_OFFSET  = 40'sd1 <<< 35;
  localparam logic signed [39:0]   F_MAX     = 40'sd2147483647;
  localparam logic signed [39:0]   F_MIN     = -40'sd2147483648;

  logic [EPS_W-1:0] eps_q;
  logic [EPS_W-1:0] eps_eff;
  logic             adv;
  logic [NST:1]     vld_q;
  side_t            side_d;
  side_t            side_q [1:NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign eps_eff = (eps_q == '0) ? EPS_W'(1) : eps_q;

  // whole pipe moves unless a finished item sits unclaimed at the output
  assign adv              = !vld_q[NST] || face_out_o.ready;
  assign face_in_i.ready  = adv;
  assign face_out_o.valid = vld_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:1], face_in_i.valid};
    end
  end

  // ---------------------------------------------------------------- stencil
  logic                     neg;
  logic signed [DATA_W-1:0] q_d [5];
  logic signed [N_W-1:0]    qn  [5];

  always_comb begin
    neg = face_in_i.velocity[DATA_W-1];
    // upwind stencil, mirrored for negative flow
    q_d[0] = neg ? face_in_i.value_p3 : face_in_i.value_m2;
    q_d[1] = neg ? face_in_i.value_p2 : face_in_i.value_m1;
    q_d[2] = neg ? face_in_i.value_p1 : face_in_i.value_c0;
    q_d[3] = neg ? face_in_i.value_c0 : face_in_i.value_p1;
    q_d[4] = neg ? face_in_i.value_m1 : face_in_i.value_p2;
    for (int i = 0; i < 5; i++) begin
      qn[i] = N_W'(q_d[i]);
    end
    side_d.zero = (face_in_i.velocity == '0);
    side_d.n1   = 2 * qn[0] - 7 * qn[1] + 11 * qn[2];
    side_d.n2   = 5 * qn[2] - qn[1] + 2 * qn[3];
    side_d.n3   = 2 * qn[2] + 5 * qn[3] - qn[4];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1] <= side_d;
      for (int j = 2; j < NST; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // ------------------------------------------------------- smoothness terms
  logic signed [DATA_W-1:0] q_q   [5];
  logic signed [35:0]       qe    [5];
  logic signed [35:0]       de    [6];  // d1..d3 then e1..e3
  logic [35:0]              de_abs[6];
  logic [MAG_W-1:0]         mag_q [6];
  logic [29:0]              hh_q  [6];
  logic [34:0]              hl_q  [6];
  logic [19:0]              ll_q  [6];
  logic [39:0]              ll_full [6];
  logic [SQ_W-1:0]          sq_q  [6];
  logic [22:0]              ind_h [3];
  logic [45:0]              ph_q  [3];
  logic [23:0]              pl_q  [3];
  logic [SQ_W-1:0]          sqd_q [3];
  logic [46:0]              e4_q  [3];
  logic [49:0]              s_sum [3];
  logic [S_W-1:0]           s_q   [3];
  logic [S_W-1:0]           s7_q  [3];
  logic [S_W-1:0]           min_d;
  logic [S_W-1:0]           min_q;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      qe[i] = 36'(q_q[i]);
    end
    de[0] = qe[0] - 2 * qe[1] + qe[2];
    de[1] = qe[1] - 2 * qe[2] + qe[3];
    de[2] = qe[2] - 2 * qe[3] + qe[4];
    de[3] = qe[0] - 4 * qe[1] + 3 * qe[2];
    de[4] = qe[1] - qe[3];
    de[5] = 3 * qe[2] - 4 * qe[3] + qe[4];
    for (int i = 0; i < 6; i++) begin
      de_abs[i]  = de[i][35] ? 36'(-de[i]) : 36'(de[i]);
      ll_full[i] = 40'(mag_q[i][19:0]) * 40'(mag_q[i][19:0]);
    end
    for (int k = 0; k < 3; k++) begin
      ind_h[k] = sq_q[k][48:26];
      s_sum[k] = 50'(sqd_q[k]) + 50'(ph_q[k]) + 50'(pl_q[k]) + 50'(e4_q[k])
               + 50'(eps_eff);
    end
    min_d = s_q[0];
    if (s_q[1] < min_d) begin
      min_d = s_q[1];
    end
    if (s_q[2] < min_d) begin
      min_d = s_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 5; i++) begin
        q_q[i] <= q_d[i];
      end
      for (int i = 0; i < 6; i++) begin
        mag_q[i] <= de_abs[i][MAG_W-1:0];
        // x^2 / 2^20 from 15-bit high and 20-bit low halves
        hh_q[i]  <= 30'(mag_q[i][34:20]) * 30'(mag_q[i][34:20]);
        hl_q[i]  <= 35'(mag_q[i][34:20]) * 35'(mag_q[i][19:0]);
        ll_q[i]  <= ll_full[i][39:20];
        sq_q[i]  <= (SQ_W'(hh_q[i]) << 20) + (SQ_W'(hl_q[i]) << 1) + SQ_W'(ll_q[i]);
      end
      for (int k = 0; k < 3; k++) begin
        // 13/12 * sq = sq + floor((sq/4) / 3)
        ph_q[k]  <= 46'(ind_h[k]) * 46'(DIV3_HI_MUL);
        pl_q[k]  <= div3_fold(25'(ind_h[k]) + 25'(sq_q[k][25:2]));
        sqd_q[k] <= sq_q[k];
        e4_q[k]  <= sq_q[k+3][48:2];
        s_q[k]   <= s_sum[k][S_W-1:0];
        s7_q[k]  <= s_q[k];
      end
      min_q <= min_d;
    end
  end

  // ------------------------------------------------------------- ratios
  logic [DIV_W-1:0] rnum [3];
  logic [DIV_W-1:0] rden [3];
  logic [QUO_W-1:0] rquo [3];
  logic [T_W-1:0]   t    [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // bring the divisor under 2^46, min shifted alike
      if (s7_q[k][47]) begin
        rden[k] = s7_q[k][47:2];
        rnum[k] = min_q[47:2];
      end else if (s7_q[k][46]) begin
        rden[k] = s7_q[k][46:1];
        rnum[k] = min_q[46:1];
      end else begin
        rden[k] = s7_q[k][45:0];
        rnum[k] = min_q[45:0];
      end
      // floor(m*2^16/s) = floor(floor(m*2^24/s) / 2^8)
      t[k] = rquo[k][QUO_W-1:WBITS-RBITS];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ratio
    w5fr_div u_ratio_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (rnum[k]),
      .den_i (rden[k]),
      .quo_o (rquo[k])
    );
  end

  // ------------------------------------------------------------- weights
  logic [33:0]      tsq_q [3];
  logic [A_W-1:0]   a_d   [3];
  logic [A_W-1:0]   sum_d;
  logic [A_W-1:0]   a1_q;
  logic [A_W-1:0]   a3_q;
  logic [A_W-1:0]   sum_q;
  logic [QUO_W-1:0] w1_quo;
  logic [QUO_W-1:0] w3_quo;
  logic [QUO_W-1:0] w_q   [3];

  always_comb begin
    a_d[0] = A_W'(tsq_q[0]);
    a_d[1] = (A_W'(tsq_q[1]) << 2) + (A_W'(tsq_q[1]) << 1);
    a_d[2] = (A_W'(tsq_q[2]) << 1) + A_W'(tsq_q[2]);
    sum_d  = a_d[0] + a_d[1] + a_d[2];
    if (sum_d == '0) begin
      sum_d = A_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        tsq_q[k] <= 34'(t[k]) * 34'(t[k]);
      end
      a1_q  <= a_d[0];
      a3_q  <= a_d[2];
      sum_q <= sum_d;
      w_q[0] <= w1_quo;
      w_q[1] <= W_ONE - w1_quo - w3_quo;
      w_q[2] <= w3_quo;
    end
  end

  w5fr_div u_w1_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DIV_W'(a1_q)),
    .den_i (DIV_W'(sum_q)),
    .quo_o (w1_quo)
  );

  w5fr_div u_w3_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DIV_W'(a3_q)),
    .den_i (DIV_W'(sum_q)),
    .quo_o (w3_quo)
  );

  // ------------------------------------------------------ blend and round
  logic signed [N_W-1:0] nsel  [3];
  logic signed [25:0]    ws    [3];
  logic signed [18:0]    nhi   [3];
  logic [42:0]           plo_q [3];
  logic signed [44:0]    phi_q [3];
  logic signed [62:0]    p_q   [3];
  logic signed [63:0]    acc_q;
  logic signed [38:0]    zq;
  logic [38:0]           u_full;
  logic [13:0]           u_h;
  logic [36:0]           dph_q;
  logic [23:0]           dpl_q;
  logic signed [39:0]    f_full;
  logic signed [DATA_W-1:0] f_sat;
  logic signed [DATA_W-1:0] face_q;

  always_comb begin
    nsel[0] = side_q[ST_PP-1].n1;
    nsel[1] = side_q[ST_PP-1].n2;
    nsel[2] = side_q[ST_PP-1].n3;
    for (int k = 0; k < 3; k++) begin
      ws[k]  = $signed({1'b0, w_q[k]});
      nhi[k] = nsel[k][N_W-1:18];
    end
    // floor(acc / 2^25), then offset so the /3 runs on a positive value
    zq     = acc_q[63:25];
    u_full = 39'(zq) + U_OFFSET;
    u_h    = u_full[37:24];
    f_full = $signed(40'(dph_q)) + $signed(40'(dpl_q)) - F_OFFSET;
    if (f_full > F_MAX) begin
      f_sat = DATA_W'(F_MAX);
    end else if (f_full < F_MIN) begin
      f_sat = DATA_W'(F_MIN);
    end else begin
      f_sat = f_full[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= 43'(w_q[k]) * 43'(nsel[k][17:0]);
        phi_q[k] <= 45'(ws[k]) * 45'(nhi[k]);
        p_q[k]   <= (63'(phi_q[k]) <<< 18) + $signed({20'b0, plo_q[k]});
      end
      acc_q  <= 64'(p_q[0]) + 64'(p_q[1]) + 64'(p_q[2]) + ACC_ROUND;
      dph_q  <= 37'(u_h) * 37'(DIV3_HI_MUL);
      dpl_q  <= div3_fold(25'(u_h) + 25'(u_full[23:0]));
      face_q <= side_q[NST-1].zero ? '0 : f_sat;
    end
  end

  assign face_out_o.face_value = face_q;

  // ------------------------------------------------------------- checks
  a_min_ratio_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_T] |-> (t[0] == T_ONE || t[1] == T_ONE || t[2] == T_ONE))
    else $error("no ratio at full scale for the least indicator");

  a_weights_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_W] |-> ({1'b0, w1_quo} + {1'b0, w3_quo} <= {1'b0, W_ONE}))
    else $error("outer weights exceed unity");

  a_zero_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[NST-1] && side_q[NST-1].zero |=> face_out_o.face_value == '0)
    else $error("zero velocity item gave non-zero face value");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

`default_nettype wire
